// ===== src/lof_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lof_pkg
// Shared constants and types for the letter order block.
// ----------------------------------------------------------------------------
package lof_pkg;

	localparam int MAX_WORD_LEN = 64;
	localparam int MAX_LETTERS  = 26;
	localparam int COUNT_BITS   = 16;

	localparam int LETTER_W = 5;
	localparam int POS_W    = $clog2(MAX_WORD_LEN + 1);
	localparam int PW_AW    = $clog2(MAX_WORD_LEN);
	localparam int EDGE_N   = MAX_LETTERS * MAX_LETTERS;
	localparam int EDGE_AW  = $clog2(EDGE_N);
	localparam int DEG_AW   = $clog2(MAX_LETTERS);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// Write and read request for one of the state memories.
	typedef struct packed {
		logic                we;
		logic [PW_AW-1:0]    waddr;
		logic [LETTER_W-1:0] wdata;
		logic [PW_AW-1:0]    raddr;
	} pw_req_t;

	typedef struct packed {
		logic                  we;
		logic [EDGE_AW-1:0]    waddr;
		logic [COUNT_BITS-1:0] wdata;
		logic [EDGE_AW-1:0]    raddr;
	} edge_req_t;

	typedef struct packed {
		logic                  we;
		logic [DEG_AW-1:0]     waddr;
		logic [COUNT_BITS-1:0] wdata;
		logic [DEG_AW-1:0]     raddr;
	} deg_req_t;

	// One result item.
	typedef struct packed {
		logic [LETTER_W-1:0] order_letter;
		logic                letter_valid;
		logic                is_last;
	} res_t;

	// Saturating increment of a count.
	function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + 1'b1;
	endfunction

endpackage

// ===== src/letter_order_from_sorted_words.sv =====
`timescale 1ns / 1ps
// A letter item goes through a previous-word read, then an edge table
// read-modify-write; the next item is taken only after it finishes. The
// sort scans the in-degrees of the k letters in use, then the neighbors
// of each queued letter, then gives one result per cycle through the output
// register while the receiver is ready. Reset is asynchronous; after reset
// and every list a clearing pass sweeps the edge table; no item is taken.
// ----------------------------------------------------------------------------
// letter_order_from_sorted_words
// Derives a letter order from a sorted word list with Kahn's sort.
// ----------------------------------------------------------------------------
module letter_order_from_sorted_words (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [4:0] cfg_wdata,   // alphabet_size
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,     // [4:0] letter, [7:5] zero
	input  logic       s_tuser,     // word_end
	input  logic       s_tlast,     // list_end
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,     // [4:0] order_letter, [7:5] zero
	output logic       m_tuser,     // letter_valid
	output logic       m_tlast      // is_last
);

	lof_pkg::pw_req_t   pw_req;
	lof_pkg::edge_req_t edge_req;
	lof_pkg::deg_req_t  deg_req;
	lof_pkg::res_t      res;
	lof_pkg::res_t      out_q;
	logic [lof_pkg::LETTER_W-1:0]   pw_rdata;
	logic [lof_pkg::COUNT_BITS-1:0] edge_rdata;
	logic [lof_pkg::COUNT_BITS-1:0] deg_rdata;
	logic res_valid;
	logic res_ready;
	logic out_valid_q;

	lof_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_letter  (s_tdata[lof_pkg::LETTER_W-1:0]),
		.in_word_end(s_tuser),
		.in_list_end(s_tlast),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.pw_req     (pw_req),
		.pw_rdata   (pw_rdata),
		.edge_req   (edge_req),
		.edge_rdata (edge_rdata),
		.deg_req    (deg_req),
		.deg_rdata  (deg_rdata)
	);

	lof_ram #(
		.WIDTH(lof_pkg::LETTER_W),
		.DEPTH(lof_pkg::MAX_WORD_LEN),
		.AW   (lof_pkg::PW_AW)
	) u_pw_ram (
		.clk  (clk),
		.we   (pw_req.we),
		.waddr(pw_req.waddr),
		.wdata(pw_req.wdata),
		.raddr(pw_req.raddr),
		.rdata(pw_rdata)
	);

	lof_ram #(
		.WIDTH(lof_pkg::COUNT_BITS),
		.DEPTH(lof_pkg::EDGE_N),
		.AW   (lof_pkg::EDGE_AW)
	) u_edge_ram (
		.clk  (clk),
		.we   (edge_req.we),
		.waddr(edge_req.waddr),
		.wdata(edge_req.wdata),
		.raddr(edge_req.raddr),
		.rdata(edge_rdata)
	);

	lof_ram #(
		.WIDTH(lof_pkg::COUNT_BITS),
		.DEPTH(lof_pkg::MAX_LETTERS),
		.AW   (lof_pkg::DEG_AW)
	) u_deg_ram (
		.clk  (clk),
		.we   (deg_req.we),
		.waddr(deg_req.waddr),
		.wdata(deg_req.wdata),
		.raddr(deg_req.raddr),
		.rdata(deg_rdata)
	);

	// Output register: takes a new item when empty or being drained.
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {3'b000, out_q.order_letter};
	assign m_tuser  = out_q.letter_valid;
	assign m_tlast  = out_q.is_last;

endmodule

// ===== src/lof_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lof_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lof_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== src/lof_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lof_ctrl
// Sequencer: letter intake with read-compare-write of the previous word and
// the edge table, then Kahn's sort over the alphabet and result emission.
// ----------------------------------------------------------------------------
module lof_ctrl (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [4:0]                          cfg_wdata,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [lof_pkg::LETTER_W-1:0]        in_letter,
	input  logic                                in_word_end,
	input  logic                                in_list_end,
	output logic                                res_valid,
	input  logic                                res_ready,
	output lof_pkg::res_t                       res,
	output lof_pkg::pw_req_t                    pw_req,
	input  logic [lof_pkg::LETTER_W-1:0]        pw_rdata,
	output lof_pkg::edge_req_t                  edge_req,
	input  logic [lof_pkg::COUNT_BITS-1:0]      edge_rdata,
	output lof_pkg::deg_req_t                   deg_req,
	input  logic [lof_pkg::COUNT_BITS-1:0]      deg_rdata
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CMP   = 4'd2;
	localparam logic [3:0] ST_UPD   = 4'd3;
	localparam logic [3:0] ST_FIN   = 4'd4;
	localparam logic [3:0] ST_S0_RD = 4'd5;
	localparam logic [3:0] ST_S0_EV = 4'd6;
	localparam logic [3:0] ST_POP   = 4'd7;
	localparam logic [3:0] ST_NB_RD = 4'd8;
	localparam logic [3:0] ST_NB_EV = 4'd9;
	localparam logic [3:0] ST_EMIT  = 4'd10;

	localparam int LW = lof_pkg::LETTER_W;
	localparam int AW = lof_pkg::EDGE_AW;
	localparam int PW = lof_pkg::POS_W;
	localparam logic [LW-1:0] NL = LW'(lof_pkg::MAX_LETTERS);
	localparam logic [AW-1:0] CLR_LAST = AW'(lof_pkg::EDGE_N - 1);
	localparam logic [PW-1:0] POS_MAX = PW'(lof_pkg::MAX_WORD_LEN);

	logic [3:0]                    state_q;
	logic [AW-1:0]                 clr_q;
	logic [4:0]                    alpha_q;
	logic [LW-1:0]                 cur_q;
	logic                          wend_q;
	logic                          lend_q;
	logic [lof_pkg::POS_W-1:0]     pos_q;
	logic [lof_pkg::POS_W-1:0]     plen_q;
	logic                          mism_q;
	logic                          havep_q;
	logic [lof_pkg::MAX_LETTERS-1:0] done_q;
	logic [LW-1:0]                 queue_q [lof_pkg::MAX_LETTERS];
	logic [LW-1:0]                 head_q;
	logic [LW-1:0]                 tail_q;
	logic [LW-1:0]                 idx_q;
	logic [LW-1:0]                 x_q;
	logic [AW-1:0]                 ea_q;

	logic [LW-1:0]                 k;
	logic                          hit;
	logic [AW-1:0]                 cmp_addr;
	logic [AW-1:0]                 nb_addr;
	logic [lof_pkg::COUNT_BITS-1:0] nd;
	logic                          res_last;

	// Letters in use: the alphabet size, capped at MAX_LETTERS.
	assign k = (alpha_q > NL) ? NL : alpha_q;

	// First mismatch against the previous word at this position.
	assign hit = havep_q && !mism_q && (pos_q < plen_q) && (pw_rdata != cur_q);

	assign cmp_addr = AW'(pw_rdata) * AW'(lof_pkg::MAX_LETTERS) + AW'(cur_q);
	assign nb_addr  = AW'(x_q) * AW'(lof_pkg::MAX_LETTERS) + AW'(idx_q);

	// Remaining in-degree after removing the edges from the popped letter.
	assign nd = (deg_rdata > edge_rdata) ? deg_rdata - edge_rdata : '0;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);
	assign res_last  = (tail_q == '0) || (head_q + 1'b1 == tail_q);

	always_comb begin
		res.order_letter = (tail_q == '0) ? '0 : queue_q[head_q];
		res.letter_valid = (tail_q != '0);
		res.is_last      = res_last;
	end

	// Memory requests by state.
	always_comb begin
		pw_req.we    = (state_q == ST_CMP);
		pw_req.waddr = pos_q[lof_pkg::PW_AW-1:0];
		pw_req.wdata = cur_q;
		pw_req.raddr = pos_q[lof_pkg::PW_AW-1:0];

		edge_req.we    = 1'b0;
		edge_req.waddr = ea_q;
		edge_req.wdata = '0;
		edge_req.raddr = nb_addr;

		deg_req.we    = 1'b0;
		deg_req.waddr = idx_q;
		deg_req.wdata = '0;
		deg_req.raddr = idx_q;

		case (state_q)
			ST_CLEAR: begin
				edge_req.we    = 1'b1;
				edge_req.waddr = clr_q;
				deg_req.we     = (clr_q < AW'(lof_pkg::MAX_LETTERS));
				deg_req.waddr  = clr_q[LW-1:0];
			end
			ST_CMP: begin
				edge_req.raddr = cmp_addr;
				deg_req.raddr  = cur_q;
			end
			ST_UPD: begin
				edge_req.we    = 1'b1;
				edge_req.wdata = lof_pkg::sat_inc(edge_rdata);
				deg_req.we     = 1'b1;
				deg_req.waddr  = cur_q;
				deg_req.wdata  = lof_pkg::sat_inc(deg_rdata);
			end
			ST_NB_EV: begin
				deg_req.we    = (edge_rdata != '0) && !done_q[idx_q];
				deg_req.wdata = nd;
			end
			default: begin
			end
		endcase
	end

	// Alphabet size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= 5'd26;
		end else if (cfg_wen) begin
			alpha_q <= cfg_wdata;
		end
	end

	// Ready queue entries need no reset.
	always_ff @(posedge clk) begin
		if (state_q == ST_S0_EV && deg_rdata == '0) begin
			queue_q[tail_q] <= idx_q;
		end else if (state_q == ST_NB_EV && edge_rdata != '0 && !done_q[idx_q] && nd == '0) begin
			queue_q[tail_q] <= idx_q;
		end
	end

	// Main sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cur_q   <= '0;
			wend_q  <= 1'b0;
			lend_q  <= 1'b0;
			pos_q   <= '0;
			plen_q  <= '0;
			mism_q  <= 1'b0;
			havep_q <= 1'b0;
			done_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			idx_q   <= '0;
			x_q     <= '0;
			ea_q    <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cur_q  <= in_letter;
						wend_q <= in_word_end;
						lend_q <= in_list_end;
						if (in_letter < k && pos_q < POS_MAX) begin
							state_q <= ST_CMP;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_CMP: begin
					pos_q <= pos_q + 1'b1;
					ea_q  <= cmp_addr;
					if (hit) begin
						mism_q  <= 1'b1;
						state_q <= ST_UPD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_UPD: begin
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (wend_q || lend_q) begin
						plen_q  <= pos_q;
						havep_q <= 1'b1;
						pos_q   <= '0;
						mism_q  <= 1'b0;
					end
					if (lend_q) begin
						idx_q   <= '0;
						head_q  <= '0;
						tail_q  <= '0;
						state_q <= ST_S0_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_S0_RD: begin
					state_q <= (idx_q == k) ? ST_POP : ST_S0_EV;
				end
				ST_S0_EV: begin
					if (deg_rdata == '0) begin
						done_q[idx_q] <= 1'b1;
						tail_q        <= tail_q + 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_S0_RD;
				end
				ST_POP: begin
					if (head_q == tail_q) begin
						head_q  <= '0;
						state_q <= ST_EMIT;
					end else begin
						x_q     <= queue_q[head_q];
						head_q  <= head_q + 1'b1;
						idx_q   <= '0;
						state_q <= ST_NB_RD;
					end
				end
				ST_NB_RD: begin
					state_q <= (idx_q == k) ? ST_POP : ST_NB_EV;
				end
				ST_NB_EV: begin
					if (edge_rdata != '0 && !done_q[idx_q] && nd == '0) begin
						done_q[idx_q] <= 1'b1;
						tail_q        <= tail_q + 1'b1;
					end
					idx_q   <= idx_q + 1'b1;
					state_q <= ST_NB_RD;
				end
				ST_EMIT: begin
					if (res_ready) begin
						if (res_last) begin
							pos_q   <= '0;
							plen_q  <= '0;
							mism_q  <= 1'b0;
							havep_q <= 1'b0;
							done_q  <= '0;
							clr_q   <= '0;
							state_q <= ST_CLEAR;
						end else begin
							head_q <= head_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

	// The queue never holds more than the whole alphabet.
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= NL) else $error("ready queue overflow");

	// The queue head never passes the tail.
	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q) else $error("queue head passed tail");

	// An accepted item drops ready in the cycle after it.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready) else $error("item overlap");

	// A stalled result keeps its value.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res)) else $error("result changed");

endmodule

// ===== dv/letter_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_order_checker
// Watches the letter and order streams of the letter order block, keeps its
// own copy of the word and edge state, runs the sort when a list ends and
// compares every order item with the oldest expected one.
// ----------------------------------------------------------------------------
module letter_order_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wen,
	input  logic [4:0] cfg_wdata,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic       s_tuser,
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,
	input  logic       m_tuser,
	input  logic       m_tlast,
	output int         fail_count,
	output int         pending_orders
);

	logic [lof_pkg::COUNT_BITS-1:0] cnt_max;
	logic [4:0]                     alpha_reg;
	logic [4:0]                     prev_word [lof_pkg::MAX_WORD_LEN];
	int                             prev_len;
	int                             pos;
	bit                             mismatch;
	bit                             have_prev;
	logic [lof_pkg::COUNT_BITS-1:0] edges [lof_pkg::EDGE_N];
	logic [lof_pkg::COUNT_BITS-1:0] indeg [lof_pkg::MAX_LETTERS];
	lof_pkg::res_t                  order_q[$];

	function automatic int letters_in_use();
		return (alpha_reg > lof_pkg::MAX_LETTERS) ? lof_pkg::MAX_LETTERS : alpha_reg;
	endfunction

	function automatic logic [lof_pkg::COUNT_BITS-1:0] bump(
		logic [lof_pkg::COUNT_BITS-1:0] v);
		return (v == cnt_max) ? v : v + 1'b1;
	endfunction

	task automatic clear_lists();
		prev_len = 0;
		pos = 0;
		mismatch = 0;
		have_prev = 0;
		foreach (prev_word[i]) prev_word[i] = '0;
		foreach (edges[i]) edges[i] = '0;
		foreach (indeg[i]) indeg[i] = '0;
	endtask

	// Kahn's sort over the letters in use; neighbors in ascending index.
	task automatic sort_letters();
		int                             k;
		int                             head;
		logic [lof_pkg::COUNT_BITS-1:0] c;
		int                             x;
		int                             ready[$];
		bit                             done[lof_pkg::MAX_LETTERS];
		lof_pkg::res_t                  r;
		k = letters_in_use();
		head = 0;
		foreach (done[i]) done[i] = 0;
		for (int i = 0; i < k; i++)
			if (indeg[i] == 0) begin
				done[i] = 1;
				ready = {ready, i};
			end
		while (head < ready.size()) begin
			x = ready[head];
			head++;
			for (int y = 0; y < k; y++) begin
				c = edges[x * lof_pkg::MAX_LETTERS + y];
				if (c == 0 || done[y])
					continue;
				indeg[y] = (indeg[y] > c) ? indeg[y] - c : '0;
				if (indeg[y] == 0) begin
					done[y] = 1;
					ready = {ready, y};
				end
			end
		end
		if (ready.size() == 0) begin
			r.order_letter = '0;
			r.letter_valid = 1'b0;
			r.is_last = 1'b1;
			order_q = {order_q, r};
		end
		foreach (ready[i]) begin
			r.order_letter = 5'(ready[i]);
			r.letter_valid = 1'b1;
			r.is_last = (i == ready.size() - 1);
			order_q = {order_q, r};
		end
	endtask

	// Letter step: compare with the previous word, record the first mismatch.
	task automatic take_item(logic [4:0] cur, bit wend, bit lend);
		int pv;
		if (cur < letters_in_use() && pos < lof_pkg::MAX_WORD_LEN) begin
			if (have_prev && !mismatch && pos < prev_len) begin
				pv = prev_word[pos];
				if (pv != cur) begin
					mismatch = 1;
					edges[pv * lof_pkg::MAX_LETTERS + cur] =
						bump(edges[pv * lof_pkg::MAX_LETTERS + cur]);
					indeg[cur] = bump(indeg[cur]);
				end
			end
			prev_word[pos] = cur;
			pos++;
		end
		if (wend || lend) begin
			prev_len = pos;
			have_prev = 1;
			pos = 0;
			mismatch = 0;
		end
		if (lend) begin
			sort_letters();
			clear_lists();
		end
	endtask

	initial begin
		cnt_max = '1;
		fail_count = 0;
		pending_orders = 0;
		alpha_reg = 5'd26;
		clear_lists();
	end

	// Sample both channels and the register port at each rising edge.
	always @(posedge clk) begin
		lof_pkg::res_t want;
		if (arst_n) begin
			if (cfg_wen)
				alpha_reg <= cfg_wdata;
			if (m_tvalid && m_tready) begin
				if (order_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected order item: %0d valid %0b last %0b",
							m_tdata, m_tuser, m_tlast);
				end else begin
					want = order_q.pop_front();
					if (m_tdata !== {3'b0, want.order_letter}
						|| m_tuser !== want.letter_valid || m_tlast !== want.is_last) begin
						fail_count++;
						if (fail_count <= 10)
							$display("order mismatch: want %0d/%0b/%0b got %0d/%0b/%0b",
								want.order_letter, want.letter_valid, want.is_last,
								m_tdata, m_tuser, m_tlast);
					end
				end
			end
			if (s_tvalid && s_tready)
				take_item(s_tdata[4:0], s_tuser, s_tlast);
		end
		pending_orders <= order_q.size();
	end

endmodule

// ===== dv/letter_order_from_sorted_words_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// letter_order_from_sorted_words_test
// Streams sorted and random word lists into the letter order block under
// several alphabet sizes, with random gaps on both sides; the checker
// predicts every emitted order.
// ----------------------------------------------------------------------------
module letter_order_from_sorted_words_test;
	logic       clk;
	logic       arst_n;
	logic       cfg_wen;
	logic [4:0] cfg_wdata;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;     // [4:0] letter, [7:5] zero
	logic       s_tuser;     // word_end
	logic       s_tlast;     // list_end
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;     // [4:0] order_letter, [7:5] zero
	logic       m_tuser;     // letter_valid
	logic       m_tlast;     // is_last
	int         fail_count;
	int         pending_orders;
	int         cycle_count;
	bit         quiet;
	int         sent;

	localparam int CYCLE_LIMIT = 3000000;

	letter_order_from_sorted_words dut (.*);
	letter_order_checker chk (.*);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	// Global watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver stalls in random bursts, none in the quiet tail.
	initial begin
		int n;
		m_tready = 0;
		@(posedge arst_n);
		forever begin
			n = $urandom_range(1, 12);
			m_tready <= 1;
			repeat ($urandom_range(1, 30)) @(posedge clk);
			if (!quiet) begin
				m_tready <= 0;
				repeat (n) @(posedge clk);
			end
		end
	end

	// Send one letter item and wait until it is taken.
	task automatic send_letter(int ltr, bit wend, bit lend);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {3'b0, ltr[4:0]};
		s_tuser <= wend;
		s_tlast <= lend;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sent++;
	endtask

	task automatic send_word(int len, int maxl, bit lend);
		for (int i = 0; i < len; i++)
			send_letter($urandom_range(0, maxl), i == len - 1, lend && i == len - 1);
	endtask

	// A list of words sorted by a random permutation of the alphabet.
	task automatic sorted_list(int nwords, int maxl);
		int perm[26];
		int w[$];
		int nw[$];
		int j;
		foreach (perm[i]) perm[i] = i;
		perm.shuffle();
		for (int i = 0; i < 4; i++) w = {w, perm[$urandom_range(0, maxl)]};
		for (int n = 0; n < nwords; n++) begin
			nw = w;
			j = $urandom_range(0, w.size() - 1);
			for (int i = 0; i < 26; i++)
				if (perm[i] == w[j]) begin
					nw[j] = perm[(i < maxl) ? i + 1 : i];
					break;
				end
			while (nw.size() > j + 1) void'(nw.pop_back());
			repeat ($urandom_range(0, 4)) nw = {nw, perm[$urandom_range(0, maxl)]};
			w = nw;
			foreach (w[i])
				send_letter(w[i], i == w.size() - 1,
					n == nwords - 1 && i == w.size() - 1);
		end
	endtask

	task automatic idle_write(int v);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_orders != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		cfg_wen <= 1;
		cfg_wdata <= 5'(v);
		@(posedge clk);
		cfg_wen <= 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_wen = 0;
		cfg_wdata = 0;
		s_tvalid = 0;
		s_tdata = 0;
		s_tuser = 0;
		s_tlast = 0;
		cycle_count = 0;
		quiet = 0;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: lone letter list, cycle, letter outside the alphabet.
		send_letter(31, 1, 1);
		send_letter(0, 1, 0);
		send_letter(1, 1, 0);
		send_letter(0, 1, 1);
		send_letter(25, 0, 0);
		send_letter(3, 0, 0);
		send_letter(2, 1, 0);
		send_letter(25, 0, 0);
		send_letter(3, 1, 0);
		send_letter(31, 0, 1);
		idle_write(1);
		send_letter(0, 1, 0);
		send_letter(1, 1, 1);
		idle_write(0);
		send_letter(0, 1, 1);
		// Long word that runs past the buffer, then a shorter prefix.
		idle_write(26);
		for (int i = 0; i < 70; i++) send_letter(i % 26, i == 69, 0);
		send_letter(0, 1, 1);

		// Random part with several alphabet sizes.
		while (sent < 300) begin
			idle_write($urandom_range(0, 1) ? $urandom_range(1, 31) : 26);
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(0, 4) == 0) begin
					repeat ($urandom_range(1, 5)) send_word($urandom_range(1, 5), 31, 0);
					send_word($urandom_range(1, 3), 31, 1);
				end else
					sorted_list($urandom_range(2, 10), $urandom_range(1, 25));
			end
		end
		quiet = 1;
		idle_write(26);
		sorted_list(12, 25);
		s_tvalid <= 0;
		@(posedge clk);
		while (pending_orders != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
src/lof_pkg.sv
src/lof_ram.sv
src/lof_ctrl.sv
src/letter_order_from_sorted_words.sv
dv/letter_order_checker.sv
dv/letter_order_from_sorted_words_test.sv
